// ===== hdl/hsv_to_rgb_converter_defines.svh =====
// ----------------------------------------------------------------------------
// HSV to RGB converter assertion macros
// Shared macros for the concurrent checks on the converter ports.
// ----------------------------------------------------------------------------
`ifndef HSV_TO_RGB_CONVERTER_DEFINES_SVH
`define HSV_TO_RGB_CONVERTER_DEFINES_SVH

// Implication check, clocked on clk, off while in reset
`define HSV2RGB_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Invariant check, clocked on clk, off while in reset
`define HSV2RGB_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error(msg);

`endif

// ===== hdl/hsv2rgb_pkg.sv =====
// ----------------------------------------------------------------------------
// HSV to RGB package
// Widths, fixed-point constants, sector codes and the divide-by-15 helper.
// ----------------------------------------------------------------------------
package hsv2rgb_pkg;

  localparam int unsigned HueW  = 15;
  localparam int unsigned QW    = 9;   // Q1.8 saturation / brightness
  localparam int unsigned ChW   = 8;
  localparam int unsigned RemW  = 12;  // hue offset inside a sector
  localparam int unsigned NumW  = 20;  // term numerator, scale 983040
  localparam int unsigned ProdW = 29;  // v * numerator
  localparam int unsigned YW    = 12;  // 255 * prod / 2^24

  localparam logic [HueW-1:0] HUE_FULL_TURN = 15'd23040;
  localparam logic [RemW-1:0] HUE_SECTOR    = 12'd3840;
  localparam logic [QW-1:0]   Q_ONE         = 9'd256;
  localparam logic [NumW-1:0] FRAC_ONE      = 20'd983040;

  // 251658240 = 15 * 2^24: shift by 24, then divide by 15
  localparam int unsigned     ScaleShift    = 24;
  localparam logic [12:0]     DIV15_RECIP   = 13'd4370;

  // Sixty-degree hue sectors
  typedef enum logic [2:0] {
    SEC_RED_YEL = 3'd0,
    SEC_YEL_GRN = 3'd1,
    SEC_GRN_CYN = 3'd2,
    SEC_CYN_BLU = 3'd3,
    SEC_BLU_MAG = 3'd4,
    SEC_MAG_RED = 3'd5
  } sector_t;

  // floor(y / 15) for y up to 3825, reciprocal multiply
  function automatic logic [ChW-1:0] div15(input logic [YW-1:0] y);
    logic [24:0] prod;
    prod = 25'(y) * 25'(DIV15_RECIP);
    return prod[23:16];
  endfunction

endpackage

// ===== hdl/hsv_to_rgb_converter.sv =====
// ----------------------------------------------------------------------------
// HSV to RGB converter
// Fixed-point HSV to 8-bit RGB, one word per clock.
// ----------------------------------------------------------------------------
// A word is taken on every clock edge where start is high; busy is never
// asserted. Each word gives one RGB word on out_red/out_green/out_blue,
// marked by out_valid for one cycle, when it leaves the last stage. The
// receiver cannot stall, and none is needed: the six-stage pipeline (clamp,
// sector split, term numerators, v multiply, scale by 255, divide by 15 with
// channel select) moves one word per stage every clock.
module hsv_to_rgb_converter
  import hsv2rgb_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [HueW-1:0]   in_hue,
  input  logic [QW-1:0]     in_saturation,
  input  logic [QW-1:0]     in_brightness,
  output logic              out_valid,
  output logic [ChW-1:0]    out_red,
  output logic [ChW-1:0]    out_green,
  output logic [ChW-1:0]    out_blue
);

  logic            accept;

  // stage 1: clamped inputs
  logic            valid1_r;
  logic [HueW-1:0] h1_r, h1_nxt;
  logic [QW-1:0]   s1_r, s1_nxt;
  logic [QW-1:0]   v1_r, v1_nxt;

  // stage 2: sector and offset
  logic            valid2_r;
  sector_t         sec2_r, sec2_nxt;
  logic [RemW-1:0] rem2_r, rem2_nxt;
  logic [QW-1:0]   s2_r;
  logic [QW-1:0]   v2_r;
  logic [HueW-1:0] base;

  // stage 3: numerators
  logic            valid3_r;
  sector_t         sec3_r;
  logic [QW-1:0]   v3_r;
  logic [NumW-1:0] np3_r, np3_nxt;
  logic [NumW-1:0] nq3_r, nq3_nxt;
  logic [NumW-1:0] nt3_r, nt3_nxt;

  // stages 4, 5 run inside the lanes
  logic            valid4_r, valid5_r;
  sector_t         sec4_r, sec5_r;
  logic [ChW-1:0]  lv, lp, lq, lt;

  // output register
  logic            out_valid_r;
  logic [ChW-1:0]  red_r, red_nxt;
  logic [ChW-1:0]  green_r, green_nxt;
  logic [ChW-1:0]  blue_r, blue_nxt;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Clamp: hue at or above a full turn goes to zero, levels above one saturate
  always_comb begin
    h1_nxt = (in_hue >= HUE_FULL_TURN) ? '0 : in_hue;
    s1_nxt = (in_saturation > Q_ONE) ? Q_ONE : in_saturation;
    v1_nxt = (in_brightness > Q_ONE) ? Q_ONE : in_brightness;
  end

  // Sector by threshold compare, offset by subtract
  always_comb begin
    if (h1_r >= 15'(5 * HUE_SECTOR)) begin
      sec2_nxt = SEC_MAG_RED;
      base     = 15'(5 * HUE_SECTOR);
    end else if (h1_r >= 15'(4 * HUE_SECTOR)) begin
      sec2_nxt = SEC_BLU_MAG;
      base     = 15'(4 * HUE_SECTOR);
    end else if (h1_r >= 15'(3 * HUE_SECTOR)) begin
      sec2_nxt = SEC_CYN_BLU;
      base     = 15'(3 * HUE_SECTOR);
    end else if (h1_r >= 15'(2 * HUE_SECTOR)) begin
      sec2_nxt = SEC_GRN_CYN;
      base     = 15'(2 * HUE_SECTOR);
    end else if (h1_r >= 15'(HUE_SECTOR)) begin
      sec2_nxt = SEC_YEL_GRN;
      base     = 15'(HUE_SECTOR);
    end else begin
      sec2_nxt = SEC_RED_YEL;
      base     = '0;
    end
    rem2_nxt = RemW'(h1_r - base);
  end

  // Numerators on the 983040 scale: p, q, t
  always_comb begin
    np3_nxt = NumW'(NumW'(Q_ONE - s2_r) * NumW'(HUE_SECTOR));
    nq3_nxt = FRAC_ONE - NumW'(NumW'(s2_r) * NumW'(rem2_r));
    nt3_nxt = FRAC_ONE - NumW'(NumW'(s2_r) * NumW'(HUE_SECTOR - rem2_r));
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid1_r    <= 1'b0;
      valid2_r    <= 1'b0;
      valid3_r    <= 1'b0;
      valid4_r    <= 1'b0;
      valid5_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      valid1_r    <= accept;
      valid2_r    <= valid1_r;
      valid3_r    <= valid2_r;
      valid4_r    <= valid3_r;
      valid5_r    <= valid4_r;
      out_valid_r <= valid5_r;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    h1_r    <= h1_nxt;
    s1_r    <= s1_nxt;
    v1_r    <= v1_nxt;
    sec2_r  <= sec2_nxt;
    rem2_r  <= rem2_nxt;
    s2_r    <= s1_r;
    v2_r    <= v1_r;
    sec3_r  <= sec2_r;
    v3_r    <= v2_r;
    np3_r   <= np3_nxt;
    nq3_r   <= nq3_nxt;
    nt3_r   <= nt3_nxt;
    sec4_r  <= sec3_r;
    sec5_r  <= sec4_r;
    red_r   <= red_nxt;
    green_r <= green_nxt;
    blue_r  <= blue_nxt;
  end

  // Four term lanes
  hsv2rgb_level u_lane_v (.clk(clk), .v(v3_r), .num(FRAC_ONE), .level(lv));
  hsv2rgb_level u_lane_p (.clk(clk), .v(v3_r), .num(np3_r),    .level(lp));
  hsv2rgb_level u_lane_q (.clk(clk), .v(v3_r), .num(nq3_r),    .level(lq));
  hsv2rgb_level u_lane_t (.clk(clk), .v(v3_r), .num(nt3_r),    .level(lt));

  // Channel select by sector
  always_comb begin
    case (sec5_r)
      SEC_RED_YEL: begin red_nxt = lv; green_nxt = lt; blue_nxt = lp; end
      SEC_YEL_GRN: begin red_nxt = lq; green_nxt = lv; blue_nxt = lp; end
      SEC_GRN_CYN: begin red_nxt = lp; green_nxt = lv; blue_nxt = lt; end
      SEC_CYN_BLU: begin red_nxt = lp; green_nxt = lq; blue_nxt = lv; end
      SEC_BLU_MAG: begin red_nxt = lt; green_nxt = lp; blue_nxt = lv; end
      default:     begin red_nxt = lv; green_nxt = lp; blue_nxt = lq; end
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_red   = red_r;
  assign out_green = green_r;
  assign out_blue  = blue_r;

endmodule

// ===== hdl/hsv2rgb_level.sv =====
// ----------------------------------------------------------------------------
// HSV to RGB channel level lane
// Two register stages: v * numerator, then times 255 and shifted by 24.
// The divide by 15 after the second stage is left combinational.
// ----------------------------------------------------------------------------
module hsv2rgb_level
  import hsv2rgb_pkg::*;
(
  input  logic            clk,
  input  logic [QW-1:0]   v,
  input  logic [NumW-1:0] num,
  output logic [ChW-1:0]  level
);

  logic [ProdW-1:0] prod_r;
  logic [YW-1:0]    scaled_r;
  logic [YW-1:0]    scaled_nxt;
  logic [ProdW+7:0] wide;

  // times 255 as shift and subtract, then drop 24 fraction bits
  always_comb begin
    wide       = {prod_r, 8'd0} - {8'd0, prod_r};
    scaled_nxt = wide[ScaleShift +: YW];
  end

  always_ff @(posedge clk) begin
    prod_r   <= ProdW'(v) * ProdW'(num);
    scaled_r <= scaled_nxt;
  end

  assign level = div15(scaled_r);

endmodule

// ===== hdl/hsv2rgb_checker.sv =====
// ----------------------------------------------------------------------------
// HSV to RGB port checker
// Watches the converter ports: fixed latency, no stall, grey and black words.
// ----------------------------------------------------------------------------
`include "hsv_to_rgb_converter_defines.svh"

module hsv2rgb_checker
  import hsv2rgb_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic            busy,
  input  logic [HueW-1:0] in_hue,
  input  logic [QW-1:0]   in_saturation,
  input  logic [QW-1:0]   in_brightness,
  input  logic            out_valid,
  input  logic [ChW-1:0]  out_red,
  input  logic [ChW-1:0]  out_green,
  input  logic [ChW-1:0]  out_blue
);

  localparam int unsigned Lat = 6;

  logic accept;
  logic accept_grey;
  logic accept_black;
  logic rgb_grey;
  logic rgb_black;

  // taken words with zero saturation or zero brightness
  assign accept       = start && !busy;
  assign accept_grey  = accept && (in_saturation == '0);
  assign accept_black = accept && (in_brightness == '0);

  // shapes of the result word
  assign rgb_grey  = (out_red == out_green) && (out_green == out_blue);
  assign rgb_black = (out_red == '0) && (out_green == '0) && (out_blue == '0);

  // never stalls the sender
  `HSV2RGB_ASSERT_ALWAYS(a_never_busy, !busy, "busy asserted")

  // every accepted word comes out after the fixed latency
  `HSV2RGB_ASSERT_IMP(a_latency, accept, ##Lat out_valid, "result word missing")

  // zero saturation gives equal channels
  `HSV2RGB_ASSERT_IMP(a_grey, out_valid && $past(accept_grey, Lat), rgb_grey, "grey word not grey")

  // zero brightness gives black
  `HSV2RGB_ASSERT_IMP(a_black, out_valid && $past(accept_black, Lat), rgb_black, "black word not black")

endmodule

bind hsv_to_rgb_converter hsv2rgb_checker u_hsv2rgb_checker (.*);
